>>> hdl/assert_macros.svh
// assertion macros used by the partitioner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define CHK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// consequent must hold whenever the antecedent holds
`define CHK_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/krbp_pkg.sv
// types, constants and step functions of the key range bucket partitioner
`default_nettype none
package krbp_pkg;

  localparam int KEY_BITS  = 80;
  localparam int QUOT_BITS = 17;
  localparam int IDX_BITS  = 2;

  localparam logic [IDX_BITS-1:0] REG_BUCKETS = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_NODES   = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_DISKS   = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_SPARE   = 2'd3;

  typedef struct packed {
    logic [15:0] key_high;
    logic [63:0] key_low;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] bucket_id;
    logic [15:0] owner_node;
    logic [15:0] local_index;
    logic [7:0]  disk_index;
  } out_beat_t;

  typedef enum logic {SC_IDLE, SC_CALC} calc_state_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] quo;
  } ndiv_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] quo;
  } ddiv_t;

  function automatic ndiv_t ndiv_step(ndiv_t x, logic [15:0] d);
    ndiv_t       r;
    logic [16:0] t;
    logic        bit_q;
    t = {x.rem, x.quo[15]};
    if (t >= {1'b0, d}) begin
      r.rem = 16'(t - {1'b0, d});
      bit_q = 1'b1;
    end else begin
      r.rem = t[15:0];
      bit_q = 1'b0;
    end
    r.quo = {x.quo[14:0], bit_q};
    return r;
  endfunction

  function automatic ddiv_t ddiv_step(ddiv_t x, logic [7:0] d);
    ddiv_t      r;
    logic [8:0] t;
    logic       bit_q;
    t = {x.rem, x.quo[15]};
    if (t >= {1'b0, d}) begin
      r.rem = 8'(t - {1'b0, d});
      bit_q = 1'b1;
    end else begin
      r.rem = t[7:0];
      bit_q = 1'b0;
    end
    r.quo = {x.quo[14:0], bit_q};
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/key_range_bucket_partitioner.sv
// Key range bucket partitioner: maps an 80-bit key to bucket, node, local index and disk.
// Channels: in (in_valid/in_ready/in_data), out (out_valid/out_ready/out_data) and a
// config write channel (cfg_valid/cfg_ready/cfg_index/cfg_data). Register 0 is the
// bucket count, 1 the node count, 2 the disk count; a zero count acts as one.
// Throughput: one key per cycle while the receiver takes results and no range width
// division runs. A key passes a 17-stage key divider (one quotient bit per stage), a
// clamp stage, an 8-stage node divider and an 8-stage disk divider (two bits per stage).
// Writing the bucket count starts a bit-serial division that forms the range width;
// in_ready and cfg_ready stay low until it has finished.
// Reset sets all three counts to one and makes the range width the full key range;
// no clearing pass is needed.
// When the receiver stalls, the whole pipeline holds and in_ready drops in the
// same cycle; nothing is lost or repeated.
`default_nettype none
module key_range_bucket_partitioner (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire krbp_pkg::in_beat_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output krbp_pkg::out_beat_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [krbp_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import krbp_pkg::*;
  `include "assert_macros.svh"

  localparam int KST = QUOT_BITS;
  localparam int NST = 8;

  calc_state_t          state, state_next;
  logic                 busy;
  logic [15:0]          nb_eff;
  logic [15:0]          nbm1;
  logic [15:0]          nn_r;
  logic [7:0]           nd_r;
  logic [KEY_BITS-1:0]  split;
  logic [15:0]          srem;
  logic [6:0]           scnt;
  logic [16:0]          st;
  logic                 cfg_fire;
  logic                 adv;

  logic                 kv   [0:KST];
  logic [KEY_BITS-1:0]  krem [0:KST];
  logic [QUOT_BITS-1:0] kq   [0:KST];
  logic [KEY_BITS-1:0]  krem_next [0:KST-1];
  logic [QUOT_BITS-1:0] kq_next   [0:KST-1];
  logic [KEY_BITS-1:0]  key;

  logic                 bv;
  logic [15:0]          bkt;

  logic                 nv   [0:NST];
  ndiv_t                nst  [0:NST];
  logic [15:0]          nbk  [0:NST];

  logic                 dv   [0:NST];
  ddiv_t                dst  [0:NST];
  logic [15:0]          dbk  [0:NST];
  logic [15:0]          down [0:NST];
  logic [15:0]          dloc [0:NST];

  assign cfg_fire  = cfg_valid && cfg_ready;
  assign adv       = !dv[NST] || out_ready;
  assign in_ready  = adv && !busy;
  assign cfg_ready = !busy;
  assign key       = {in_data.key_high, in_data.key_low};

  // range width divider state machine
  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: if (cfg_fire && cfg_index == REG_BUCKETS) state_next = SC_CALC;
      SC_CALC: if (scnt == 7'(KEY_BITS - 1)) state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      SC_CALC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  assign st = {srem, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SC_IDLE;
      nb_eff <= 16'd1;
      nbm1   <= '0;
      nn_r   <= 16'd1;
      nd_r   <= 8'd1;
      split  <= '1;
      srem   <= '0;
      scnt   <= '0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_BUCKETS: begin
            nb_eff <= (cfg_data == '0) ? 16'd1 : cfg_data;
            nbm1   <= (cfg_data == '0) ? 16'd0 : 16'(cfg_data - 16'd1);
            srem   <= '0;
            scnt   <= '0;
          end
          REG_NODES: nn_r <= (cfg_data == '0) ? 16'd1 : cfg_data;
          REG_DISKS: nd_r <= (cfg_data[7:0] == '0) ? 8'd1 : cfg_data[7:0];
          default: ;
        endcase
      end
      if (busy) begin
        if (st >= {1'b0, nb_eff}) begin
          srem  <= 16'(st - {1'b0, nb_eff});
          split <= {split[KEY_BITS-2:0], 1'b1};
        end else begin
          srem  <= st[15:0];
          split <= {split[KEY_BITS-2:0], 1'b0};
        end
        scnt <= 7'(scnt + 7'd1);
      end
    end
  end

  // one quotient bit per key stage
  always_comb begin
    for (int s = 0; s < KST; s++) begin
      if ((krem[s] >> (KST - 1 - s)) >= split) begin
        krem_next[s] = krem[s] - (split << (KST - 1 - s));
        kq_next[s]   = kq[s] | (QUOT_BITS'(1) << (KST - 1 - s));
      end else begin
        krem_next[s] = krem[s];
        kq_next[s]   = kq[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= KST; s++) kv[s] <= 1'b0;
      bv <= 1'b0;
      for (int s = 0; s <= NST; s++) begin
        nv[s] <= 1'b0;
        dv[s] <= 1'b0;
      end
    end else if (adv) begin
      kv[0] <= in_valid && in_ready;
      for (int s = 0; s < KST; s++) kv[s+1] <= kv[s];
      bv    <= kv[KST];
      nv[0] <= bv;
      for (int s = 0; s < NST; s++) nv[s+1] <= nv[s];
      dv[0] <= nv[NST];
      for (int s = 0; s < NST; s++) dv[s+1] <= dv[s];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      krem[0] <= (key == '0) ? '0 : key - KEY_BITS'(1);
      kq[0]   <= '0;
      for (int s = 0; s < KST; s++) begin
        krem[s+1] <= krem_next[s];
        kq[s+1]   <= kq_next[s];
      end
      bkt    <= (kq[KST] < {1'b0, nbm1}) ? kq[KST][15:0] : nbm1;
      nst[0] <= '{rem: 16'd0, quo: bkt};
      nbk[0] <= bkt;
      for (int s = 0; s < NST; s++) begin
        nst[s+1] <= ndiv_step(ndiv_step(nst[s], nn_r), nn_r);
        nbk[s+1] <= nbk[s];
      end
      dst[0]  <= '{rem: 8'd0, quo: nst[NST].quo};
      dloc[0] <= nst[NST].quo;
      down[0] <= nst[NST].rem;
      dbk[0]  <= nbk[NST];
      for (int s = 0; s < NST; s++) begin
        dst[s+1]  <= ddiv_step(ddiv_step(dst[s], nd_r), nd_r);
        dloc[s+1] <= dloc[s];
        down[s+1] <= down[s];
        dbk[s+1]  <= dbk[s];
      end
    end
  end

  assign out_valid            = dv[NST];
  assign out_data.bucket_id   = dbk[NST];
  assign out_data.owner_node  = down[NST];
  assign out_data.local_index = dloc[NST];
  assign out_data.disk_index  = dst[NST].rem;

  `CHK_IMP(a_busy_blocks_in, busy, !in_ready && !cfg_ready)
  `CHK_IMP(a_owner_range, out_valid, out_data.owner_node < nn_r)
  `CHK_IMP(a_bucket_range, out_valid, out_data.bucket_id <= nbm1)
  `CHK(a_disk_range, !out_valid || out_data.disk_index < nd_r)

endmodule
`default_nettype wire

>>> tb/key_range_bucket_partitioner_tb.sv
// self-checking testbench for the key range bucket partitioner
`timescale 1ns / 100ps
`default_nettype none
module key_range_bucket_partitioner_tb;
  import krbp_pkg::*;

  class bucket_scoreboard;
    logic [15:0] buckets, nodes;
    logic [7:0]  disks;
    out_beat_t   placements[$];
    int          errors;
    int          checked;

    function new();
      buckets = 16'd1;
      nodes   = 16'd1;
      disks   = 8'd1;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [IDX_BITS-1:0] idx, logic [15:0] val);
      case (idx)
        REG_BUCKETS: buckets = val;
        REG_NODES:   nodes = val;
        REG_DISKS:   disks = val[7:0];
        default: ;
      endcase
    endfunction

    function void note_key(in_beat_t k);
      logic [79:0] key, split, q;
      logic [15:0] nb, nn, bkt, loc;
      logic [7:0]  nd;
      out_beat_t   p;
      nb = (buckets == 0) ? 16'd1 : buckets;
      nn = (nodes == 0) ? 16'd1 : nodes;
      nd = (disks == 0) ? 8'd1 : disks;
      key = {k.key_high, k.key_low};
      split = {80{1'b1}} / {64'd0, nb};
      q = (key == 0) ? 80'd0 : (key - 80'd1) / split;
      bkt = (q < {64'd0, nb} - 80'd1) ? q[15:0] : nb - 16'd1;
      loc = bkt / nn;
      p.bucket_id   = bkt;
      p.owner_node  = bkt % nn;
      p.local_index = loc;
      p.disk_index  = 8'(loc % {8'd0, nd});
      placements = {placements, p};
    endfunction

    function void check_result(out_beat_t a);
      out_beat_t e;
      if (placements.size() == 0) begin
        $error("unexpected result beat %h", a);
        errors++;
        return;
      end
      e = placements.pop_front();
      checked++;
      if (a.bucket_id !== e.bucket_id) begin
        $error("bucket_id exp %0d got %0d", e.bucket_id, a.bucket_id);
        errors++;
      end
      if (a.owner_node !== e.owner_node) begin
        $error("owner_node exp %0d got %0d", e.owner_node, a.owner_node);
        errors++;
      end
      if (a.local_index !== e.local_index) begin
        $error("local_index exp %0d got %0d", e.local_index, a.local_index);
        errors++;
      end
      if (a.disk_index !== e.disk_index) begin
        $error("disk_index exp %0d got %0d", e.disk_index, a.disk_index);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  in_beat_t in_data = '0;
  logic out_valid, out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [IDX_BITS-1:0] cfg_index = REG_BUCKETS;
  logic [15:0] cfg_data = '0;

  int send_idle = 0, recv_idle = 0;
  int stall_cycles = 0;
  int keys_sent = 0, cfg_writes = 0;
  bucket_scoreboard sb = new();

  localparam int STALL_LIMIT = 5000;
  localparam int LATENCY = 40;

  always #10 clk = ~clk;

  key_range_bucket_partitioner i_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // valid stays high between back to back beats; drain drops it
  task automatic send_key(logic [15:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{key_high: hi, key_low: lo};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_key(in_data);
    keys_sent++;
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.placements.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] nb, logic [15:0] nn, logic [7:0] nd);
    drain();
    write_reg(REG_BUCKETS, nb);
    write_reg(REG_NODES, nn);
    write_reg(REG_DISKS, {8'd0, nd});
  endtask

  function automatic logic [79:0] rand_key();
    case ($urandom_range(3))
      0: return 80'({$urandom(), $urandom(), $urandom()});
      1: return {16'(0), $urandom(), $urandom()} >> $urandom_range(63);
      2: return ~({16'(0), $urandom(), $urandom()} >> $urandom_range(63));
      default: return 80'({$urandom(), $urandom(), $urandom()} >> $urandom_range(79));
    endcase
  endfunction

  task automatic send_near_bound(logic [15:0] nb);
    logic [79:0] split, k;
    logic [15:0] i;
    split = {80{1'b1}} / {64'd0, (nb == 0) ? 16'd1 : nb};
    i = 16'($urandom_range(((nb == 0) ? 1 : nb) - 1));
    k = split * ({64'd0, i} + 80'd1) + 80'($signed(3'($urandom_range(4)) - 3'd2));
    send_key(k[79:64], k[63:0]);
  endtask

  initial begin
    logic [79:0] k;
    logic [15:0] nb, nn;
    logic [7:0] nd;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes with reset counts, extreme settings, keys near bucket bounds
    send_key(16'h0000, 64'h0);
    send_key(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_key(16'h0000, 64'h1);
    configure(16'hFFFF, 16'hFFFF, 8'hFF);
    send_key(16'h0000, 64'h0);
    send_key(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_key(16'h0001, 64'h0);
    send_key(16'h8000, 64'h0);
    send_key(16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF);
    configure(16'd0, 16'd0, 8'd0);
    send_key(16'hAAAA, 64'h5555_5555_5555_5555);
    send_key(16'h5555, 64'hAAAA_AAAA_AAAA_AAAA);
    configure(16'd7, 16'd3, 8'd2);
    repeat (6) send_near_bound(16'd7);
    configure(16'd24, 16'd4, 8'd3);
    repeat (4) send_near_bound(16'd24);
    drain();
    write_reg(REG_SPARE, 16'h1234);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 9 : (ph == 1) ? 54 : 0;
      recv_idle = (ph == 0) ? 54 : (ph == 1) ? 9 : 0;
      for (int s = 0; s < 6; s++) begin
        case ($urandom_range(3))
          0: begin nb = 16'($urandom_range(1, 16)); nn = 16'($urandom_range(1, 4));
                   nd = 8'($urandom_range(1, 4)); end
          1: begin nb = 16'hFFFF - 16'($urandom_range(3)); nn = 16'($urandom());
                   nd = 8'($urandom()); end
          2: begin nn = 16'($urandom_range(1, 16)); nd = 8'($urandom_range(1, 8));
                   nb = nn * nd * 16'($urandom_range(1, 64)); end
          default: begin nb = 16'($urandom()); nn = 16'($urandom_range(0, 300));
                   nd = 8'($urandom()); end
        endcase
        configure(nb, nn, nd);
        if ($urandom_range(3) == 0) write_reg(REG_SPARE, 16'($urandom()));
        for (int n = 0; n < 100; n++) begin
          if ($urandom_range(2) == 0) send_near_bound(nb);
          else begin
            k = rand_key();
            send_key(k[79:64], k[63:0]);
          end
        end
      end
    end

    drain();
    $display("sent %0d keys through %0d register writes; %0d results checked",
             keys_sent, cfg_writes, sb.checked);
    $display("settings covered min, max, zero and random bucket/node/disk counts");
    if (sb.errors == 0 && sb.placements.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
